// ===== rtl/core/arc_pkg.sv =====
// shared types, constants and keyword table for the modem reply classifier
package arc_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);

  localparam int NUM_KW = 16;
  localparam int KW_MAX = 11;
  localparam int POS_W = 4;

  localparam int KIND_W = 3;
  localparam int REQ_W = 8;
  localparam int ERRN_W = 16;
  localparam int LSTART_W = 8;
  localparam int RLEN_W = 9;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_GT = 8'h3e;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // keyword indexes
  localparam int KW_OK = 0;
  localparam int KW_ERROR = 1;
  localparam int KW_CMS = 2;
  localparam int KW_CME = 3;
  localparam int KW_RING = 4;
  localparam int KW_NODIAL = 9;
  localparam int KW_CREG = 10;
  localparam int KW_CPIN = 11;
  localparam int KW_CRING = 12;
  localparam int KW_CLCC = 14;
  localparam int KW_CMTI = 15;

  // strings are right-justified: the first character sits in the highest used byte
  localparam logic [KW_MAX*8-1:0] KW_STR [NUM_KW] = '{
    "OK", "ERROR", "+CMS ERROR:", "+CME ERROR:", "RING", "CONNECT", "BUSY",
    "NO ANSWER", "NO CARRIER", "NO DIALTONE", "+CREG:", "+CPIN:", "+CRING:",
    "+CLIP:", "+CLCC:", "+CMTI:"
  };
  localparam logic [POS_W-1:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd5, 4'd11, 4'd11, 4'd4, 4'd7, 4'd4, 4'd9, 4'd10, 4'd11, 4'd6, 4'd6,
    4'd7, 4'd6, 4'd6, 4'd6
  };
  localparam logic [POS_W-1:0] NUM_POS = 4'd11;
  localparam logic [CNT_W-1:0] MIN_ERROR_FILL = CNT_W'(7);

  typedef enum logic [KIND_W-1:0] {
    KIND_OK      = 3'd0,
    KIND_ERROR   = 3'd1,
    KIND_CMS     = 3'd2,
    KIND_CME     = 3'd3,
    KIND_CALL    = 3'd4,
    KIND_NETWORK = 3'd5,
    KIND_SMS     = 3'd6,
    KIND_PROMPT  = 3'd7
  } reply_kind_t;

  typedef enum logic [2:0] {
    PS_WS,
    PS_PLUS,
    PS_DIG,
    PS_DONE,
    PS_FAIL
  } num_state_t;

  localparam logic [2:0] REG_PENDING = 3'd0;

  typedef struct packed {
    reply_kind_t           kind;
    logic                  unsol;
    logic [REQ_W-1:0]      req;
    logic [ERRN_W-1:0]     errn;
    logic [LSTART_W-1:0]   lstart;
    logic [RLEN_W-1:0]     rlen;
    logic                  ovf;
  } arc_evt_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) ||
               (c == 8'h0c) || (c == 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== rtl/core/at_response_classifier_top.sv =====
// top level of the modem reply classifier
//
// in_ stream: one received modem byte per transaction in in_tdata[7:0].
// out_ stream: one transaction per recognized reply; out_tuser holds the
// reply kind and the unsolicited flag, out_tdata the echoed request type,
// error number, line start, reply length and overflow flag.
// cfg: APB-style port, register 0 at address 0 holds the pending request
// type; pready is always high, writes land in the access cycle.
// Throughput: one byte per cycle while in_tready is high; line matching is done incrementally as
// each byte arrives, so the line end needs no buffer rescan.
// The event for a reply is written into the queue when the byte ending it is
// accepted and then moves to the output register, which drives out_tvalid.
// A two-entry event queue sits between the classifier and the output
// register; when the receiver stalls, in_tready drops only once both the
// queue is full and the output register holds a result.
// Reset (rst_n low, synchronous) empties the buffer, the queue and the
// output register and clears the pending request type.
module at_response_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // request_type, error_number, line_start, reply_length, overflowed
  output logic [3:0]  out_tuser,  // reply_kind, unsolicited
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import arc_pkg::*;

  logic             acc, push, q_full, q_empty, q_pop;
  arc_evt_t         f_evt, q_evt;
  logic [REQ_W-1:0] pend_r, pend_nxt;

  assign pready = 1'b1;
  assign in_tready = !q_full;
  assign acc = in_tvalid && in_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (psel && penable && pwrite && pready && {paddr[2], 2'b00} == REG_PENDING) begin
      pend_nxt = pwdata[REQ_W-1:0];
    end
    prdata = ({paddr[2], 2'b00} == REG_PENDING) ? {24'd0, pend_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  arc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_tdata),
    .pending (pend_r),
    .push    (push),
    .evt     (f_evt)
  );

  arc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_evt (f_evt),
    .pop    (q_pop),
    .rd_evt (q_evt),
    .full   (q_full),
    .empty  (q_empty)
  );

  arc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_evt      (q_evt),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/arc_front.sv =====
// front end: tracks the buffer and the current line, classifies at each line end and prompt
module arc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [7:0]                 rx_byte,
  input  logic [arc_pkg::REQ_W-1:0]  pending,
  output logic                       push,
  output arc_pkg::arc_evt_t          evt
);
  import arc_pkg::*;

  logic [CNT_W-1:0]  fill_r, fill_nxt, ls_r, ls_nxt, n;
  logic [7:0]        h1_r, h2_r, h3_r, h1_nxt, h2_nxt, h3_nxt;
  logic              ovf_r, ovf_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_upd;
  logic [NUM_KW-1:0] fl_r, fl_nxt, fl_upd, hit;
  logic [2:0]        comma_r, comma_nxt, comma_upd;
  logic              cr_r, cr_nxt, cr_upd;
  num_state_t        ps_r, ps_nxt, ps_upd;
  logic [ERRN_W-1:0] num_r, num_nxt, num_upd;
  logic              num_ok;
  logic              line_end, prompt, found;
  reply_kind_t       kind;
  logic              unsol;

  assign n = fill_r + CNT_W'(1);

  // keyword flags, line position, comma count and CR flag with the current byte applied
  always_comb begin
    fl_upd = fl_r;
    hit = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (pos_r < KW_LEN[k]) begin
        fl_upd[k] = fl_r[k] &
          (rx_byte == KW_STR[k][(int'(KW_LEN[k]) - 1 - int'(pos_r)) * 8 +: 8]);
      end
      hit[k] = fl_upd[k] && ({1'b0, pos_r} + 5'd1 >= {1'b0, KW_LEN[k]});
    end
    pos_upd = (pos_r == NUM_POS) ? pos_r : pos_r + POS_W'(1);
    cr_upd = cr_r | (rx_byte == CH_CR);
    comma_upd = (!cr_r && rx_byte != CH_CR && rx_byte == CH_COMMA) ? comma_r + 3'd1
                                                                     : comma_r;
  end

  // number after the error prefix: next state
  always_comb begin
    ps_upd = ps_r;
    if (pos_r == NUM_POS) begin
      case (ps_r)
        PS_WS: begin
          if (is_space(rx_byte)) ps_upd = PS_WS;
          else if (rx_byte == CH_PLUS) ps_upd = PS_PLUS;
          else if (is_digit(rx_byte)) ps_upd = PS_DIG;
          else ps_upd = PS_FAIL;
        end
        PS_PLUS: ps_upd = is_digit(rx_byte) ? PS_DIG : PS_FAIL;
        PS_DIG:  ps_upd = is_digit(rx_byte) ? PS_DIG : PS_DONE;
        PS_DONE: ps_upd = PS_DONE;
        PS_FAIL: ps_upd = PS_FAIL;
        default: ps_upd = PS_FAIL;
      endcase
    end
  end

  // number after the error prefix: value
  always_comb begin
    num_upd = num_r;
    if (pos_r == NUM_POS && is_digit(rx_byte) &&
        (ps_r == PS_WS || ps_r == PS_PLUS)) begin
      num_upd = ERRN_W'(rx_byte - CH_ZERO);
    end else if (pos_r == NUM_POS && is_digit(rx_byte) && ps_r == PS_DIG) begin
      num_upd = {num_r[ERRN_W-4:0], 3'b000} + {num_r[ERRN_W-2:0], 1'b0} +
                ERRN_W'(rx_byte - CH_ZERO);
    end
    num_ok = (ps_upd == PS_DIG) || (ps_upd == PS_DONE);
  end

  // priority match on the finished line or on a prompt
  always_comb begin
    line_end = (fill_r >= CNT_W'(3)) && (h1_r == CH_CR) && (rx_byte == CH_LF);
    prompt = (fill_r >= CNT_W'(3)) && (h3_r == CH_CR) && (h2_r == CH_LF) &&
             (h1_r == CH_GT) && (rx_byte == CH_SP);
    found = 1'b1;
    kind = KIND_OK;
    unsol = 1'b0;
    if (prompt) begin
      kind = KIND_PROMPT;
    end else if (!line_end) begin
      found = 1'b0;
    end else if (hit[KW_OK]) begin
      kind = KIND_OK;
    end else if (hit[KW_ERROR] && n >= MIN_ERROR_FILL) begin
      kind = KIND_ERROR;
    end else if (hit[KW_CMS] && num_ok) begin
      kind = KIND_CMS;
    end else if (hit[KW_CME] && num_ok) begin
      kind = KIND_CME;
    end else if (|hit[KW_NODIAL:KW_RING]) begin
      kind = KIND_CALL;
      unsol = 1'b1;
    end else if (hit[KW_CREG]) begin
      found = (comma_upd == 3'd2);
      kind = KIND_NETWORK;
      unsol = 1'b1;
    end else if (hit[KW_CPIN]) begin
      kind = KIND_OK;
    end else if (|hit[KW_CLCC:KW_CRING]) begin
      kind = KIND_CALL;
      unsol = 1'b1;
    end else if (hit[KW_CMTI]) begin
      kind = KIND_SMS;
      unsol = 1'b1;
    end else begin
      found = 1'b0;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    ls_nxt = ls_r;
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    h3_nxt = h3_r;
    ovf_nxt = ovf_r;
    pos_nxt = pos_r;
    fl_nxt = fl_r;
    comma_nxt = comma_r;
    cr_nxt = cr_r;
    ps_nxt = ps_r;
    num_nxt = num_r;
    push = 1'b0;
    if (acc) begin
      if (fill_r == CNT_W'(BUF_DEPTH)) begin
        ovf_nxt = 1'b1;
        if (rx_byte == CH_LF) begin
          fill_nxt = '0;
          ls_nxt = '0;
        end
      end else begin
        fill_nxt = n;
        h1_nxt = rx_byte;
        h2_nxt = h1_r;
        h3_nxt = h2_r;
        pos_nxt = pos_upd;
        fl_nxt = fl_upd;
        comma_nxt = comma_upd;
        cr_nxt = cr_upd;
        ps_nxt = ps_upd;
        num_nxt = num_upd;
        if (n == CNT_W'(2) && h1_r == CH_CR && rx_byte == CH_LF) begin
          // leading empty line
          fill_nxt = '0;
          ls_nxt = '0;
        end else if (found) begin
          push = 1'b1;
          fill_nxt = '0;
          ls_nxt = '0;
          ovf_nxt = 1'b0;
        end else if (rx_byte == CH_LF) begin
          ls_nxt = n;
        end
      end
      if (ls_nxt != ls_r || fill_nxt == '0) begin
        pos_nxt = '0;
        fl_nxt = '1;
        comma_nxt = '0;
        cr_nxt = 1'b0;
        ps_nxt = PS_WS;
        num_nxt = '0;
      end
    end
  end

  always_comb begin
    evt.kind = kind;
    evt.unsol = unsol;
    evt.req = unsol ? '0 : pending;
    evt.errn = (kind == KIND_CMS || kind == KIND_CME) ? num_upd : '0;
    evt.lstart = LSTART_W'(ls_r);
    evt.rlen = RLEN_W'(n);
    evt.ovf = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ls_r <= '0;
      ovf_r <= 1'b0;
      pos_r <= '0;
      fl_r <= '1;
      comma_r <= '0;
      cr_r <= 1'b0;
      ps_r <= PS_WS;
      num_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      ls_r <= ls_nxt;
      ovf_r <= ovf_nxt;
      pos_r <= pos_nxt;
      fl_r <= fl_nxt;
      comma_r <= comma_nxt;
      cr_r <= cr_nxt;
      ps_r <= ps_nxt;
      num_r <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    h3_r <= h3_nxt;
  end

endmodule

// ===== rtl/core/arc_queue.sv =====
// short event queue between the classifier and the output stage
module arc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  arc_pkg::arc_evt_t wr_evt,
  input  logic              pop,
  output arc_pkg::arc_evt_t rd_evt,
  output logic              full,
  output logic              empty
);
  import arc_pkg::*;

  arc_evt_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rd_evt = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt = pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_evt;
    end
  end

endmodule

// ===== rtl/core/arc_back.sv =====
// back end: output register that drives the result stream
module arc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  arc_pkg::arc_evt_t q_evt,
  output logic              q_pop,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [47:0]       out_tdata,  // request_type, error_number, line_start, reply_length, overflowed
  output logic [3:0]        out_tuser   // reply_kind, unsolicited
);
  import arc_pkg::*;

  logic     vld_r, vld_nxt;
  arc_evt_t evt_r;

  assign q_pop = !q_empty && (!vld_r || out_tready);
  assign vld_nxt = q_pop ? 1'b1 : (out_tready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      evt_r <= q_evt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser = {evt_r.unsol, evt_r.kind};
  assign out_tdata = {6'd0, evt_r.ovf, evt_r.rlen, evt_r.lstart, evt_r.errn, evt_r.req};

endmodule

// ===== rtl/core/arc_checker.sv =====
// port-level checks for the modem reply classifier
module arc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [3:0]  out_tuser
);
  import arc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // unsolicited replies are call, network or sms events
  a_unsol_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |->
      (out_tuser[2:0] == KIND_CALL || out_tuser[2:0] == KIND_NETWORK ||
       out_tuser[2:0] == KIND_SMS))
    else $error("unsolicited flag on a solicited kind");

  // unsolicited replies carry no request type
  a_unsol_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tdata[7:0] == 8'd0)
    else $error("request type echoed on unsolicited reply");

  // an error number only comes with cms or cme errors
  a_errn_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:8] != 16'd0 |->
      (out_tuser[2:0] == KIND_CMS || out_tuser[2:0] == KIND_CME))
    else $error("error number on a non-error reply");

endmodule

bind at_response_classifier_top arc_checker u_arc_checker (.*);

// ===== tb/at_response_classifier_top_tb.sv =====
// testbench for the modem reply classifier: byte stream in, classified replies checked out
`timescale 1ns / 100ps

module at_response_classifier_top_tb;
  import arc_pkg::*;

  typedef struct {
    reply_kind_t kind;
    logic        unsol;
    logic [7:0]  req;
    logic [15:0] errn;
    logic [7:0]  lstart;
    logic [8:0]  rlen;
    logic        ovf;
  } reply_evt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // request_type, error_number, line_start, reply_length, overflowed
  logic [3:0]  out_tuser;       // reply_kind, unsolicited
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  at_response_classifier_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // classifier copy
  logic [7:0]  line_buf [BUF_DEPTH];
  int          fill = 0;
  int          cur_start = 0;
  logic        ovf_seen = 1'b0;
  logic [7:0]  pend_type = '0;

  logic [7:0]  byte_q [$];
  reply_evt_t  reply_q [$];
  int          snd_idle = 15;
  int          rcv_idle = 60;
  bit          took_byte = 0;
  int          errors = 0;
  int          n_bytes = 0;
  int          n_replies = 0;
  int          cycles = 0;

  function automatic bit has_pfx(input int at, input string kw);
    for (int i = 0; i < kw.len(); i++) begin
      if (at + i >= fill) return 0;
      if (line_buf[at + i] != kw[i]) return 0;
    end
    return 1;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0c || c == 8'h0d;
  endfunction

  function automatic bit scan_number(input int p, output logic [15:0] num);
    int acc;
    acc = 0;
    num = '0;
    while (p < fill && is_ws(line_buf[p])) p++;
    if (p < fill && line_buf[p] == "+") p++;
    if (p >= fill || line_buf[p] < "0" || line_buf[p] > "9") return 0;
    while (p < fill && line_buf[p] >= "0" && line_buf[p] <= "9") begin
      acc = (acc * 10 + (line_buf[p] - "0")) & 16'hffff;
      p++;
    end
    num = acc[15:0];
    return 1;
  endfunction

  // returns -1 when the line is not a known reply
  function automatic int match_line(input int s, output bit un, output logic [15:0] num);
    string calls [6] = '{"RING", "CONNECT", "BUSY", "NO ANSWER", "NO CARRIER", "NO DIALTONE"};
    string rings [3] = '{"CRING:", "CLIP:", "CLCC:"};
    int commas;
    un = 0;
    num = '0;
    if (has_pfx(s, "OK")) return KIND_OK;
    if (fill >= 7 && has_pfx(s, "ERROR")) return KIND_ERROR;
    if (has_pfx(s, "+CMS ERROR:") && scan_number(s + 11, num)) return KIND_CMS;
    if (has_pfx(s, "+CME ERROR:") && scan_number(s + 11, num)) return KIND_CME;
    foreach (calls[i]) if (has_pfx(s, calls[i])) begin
      un = 1;
      return KIND_CALL;
    end
    if (s < fill && line_buf[s] == "+") begin
      if (has_pfx(s + 1, "CREG:")) begin
        commas = 0;
        for (int p = s; p < fill && line_buf[p] != 8'h0d; p++)
          if (line_buf[p] == ",") commas = (commas + 1) & 7;
        if (commas == 2) begin
          un = 1;
          return KIND_NETWORK;
        end
        return -1;
      end
      if (has_pfx(s + 1, "CPIN:")) return KIND_OK;
      foreach (rings[i]) if (has_pfx(s + 1, rings[i])) begin
        un = 1;
        return KIND_CALL;
      end
      if (has_pfx(s + 1, "CMTI:")) begin
        un = 1;
        return KIND_SMS;
      end
    end
    return -1;
  endfunction

  task automatic classify_byte(input logic [7:0] b);
    int kind;
    bit un;
    logic [15:0] num;
    reply_evt_t ev;
    kind = -1;
    un = 0;
    num = '0;
    if (fill >= BUF_DEPTH) begin
      ovf_seen = 1;
      if (b == 8'h0a) begin
        fill = 0;
        cur_start = 0;
      end
      return;
    end
    line_buf[fill] = b;
    fill++;
    if (fill == 2 && line_buf[0] == 8'h0d && line_buf[1] == 8'h0a) begin
      fill = 0;
      cur_start = 0;
      return;
    end
    if (fill >= 4 && line_buf[fill-2] == 8'h0d && line_buf[fill-1] == 8'h0a)
      kind = match_line(cur_start, un, num);
    if (fill >= 4 && line_buf[fill-4] == 8'h0d && line_buf[fill-3] == 8'h0a &&
        line_buf[fill-2] == 8'h3e && line_buf[fill-1] == 8'h20) begin
      kind = KIND_PROMPT;
      un = 0;
    end
    if (kind < 0) begin
      if (b == 8'h0a) cur_start = fill;
      return;
    end
    ev.kind = reply_kind_t'(kind[2:0]);
    ev.unsol = un;
    ev.req = un ? 8'h00 : pend_type;
    ev.errn = (kind == KIND_CMS || kind == KIND_CME) ? num : 16'h0;
    ev.lstart = cur_start[7:0];
    ev.rlen = fill[8:0];
    ev.ovf = ovf_seen;
    reply_q.push_back(ev);
    fill = 0;
    cur_start = 0;
    ovf_seen = 0;
  endtask

  // input driver and output ready generator
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || took_byte) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_tvalid <= 1'b1;
          in_tdata <= byte_q[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
    took_byte = 0;
  end

  // monitor and checker
  always @(posedge clk) begin
    reply_evt_t ev;
    cycles++;
    if (cycles > 400000) begin
      $display("at_response_classifier_top regression: fail");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      classify_byte(in_tdata);
      void'(byte_q.pop_front());
      took_byte = 1;
      n_bytes++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected reply transaction tuser=%h tdata=%h", out_tuser, out_tdata);
        errors++;
      end else begin
        ev = reply_q.pop_front();
        n_replies++;
        if (out_tuser[2:0] != ev.kind) begin
          $error("reply_kind expected %0d actual %0d", ev.kind, out_tuser[2:0]); errors++;
        end
        if (out_tuser[3] != ev.unsol) begin
          $error("unsolicited expected %0d actual %0d", ev.unsol, out_tuser[3]); errors++;
        end
        if (out_tdata[7:0] != ev.req) begin
          $error("request_type expected %0d actual %0d", ev.req, out_tdata[7:0]); errors++;
        end
        if (out_tdata[23:8] != ev.errn) begin
          $error("error_number expected %0d actual %0d", ev.errn, out_tdata[23:8]); errors++;
        end
        if (out_tdata[31:24] != ev.lstart) begin
          $error("line_start expected %0d actual %0d", ev.lstart, out_tdata[31:24]); errors++;
        end
        if (out_tdata[40:32] != ev.rlen) begin
          $error("reply_length expected %0d actual %0d", ev.rlen, out_tdata[40:32]); errors++;
        end
        if (out_tdata[41] != ev.ovf) begin
          $error("overflowed expected %0d actual %0d", ev.ovf, out_tdata[41]); errors++;
        end
      end
    end
  end

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_PENDING) pend_type = data[7:0];
  endtask

  task automatic drain();
    wait (byte_q.size() == 0);
    wait (reply_q.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic add_error_line(input string head);
    string s;
    s = head;
    repeat ($urandom_range(0, 2)) s = {s, " "};
    case ($urandom_range(0, 5))
      0: s = {s, "+"};
      1: s = {s, "-"};
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) s = {s, $sformatf("%0d", $urandom_range(0, 9999999))};
    add_str({s, "\r\n"});
  endtask

  task automatic add_random_line();
    string s;
    case ($urandom_range(0, 19))
      0: add_str("OK\r\n");
      1: add_str("ERROR\r\n");
      2, 3: add_error_line("+CMS ERROR:");
      4, 5: add_error_line("+CME ERROR:");
      6: begin
        case ($urandom_range(0, 5))
          0: s = "RING"; 1: s = "CONNECT 9600"; 2: s = "BUSY";
          3: s = "NO ANSWER"; 4: s = "NO CARRIER"; default: s = "NO DIALTONE";
        endcase
        add_str({s, "\r\n"});
      end
      7, 8: begin
        s = "+CREG: 1";
        repeat ($urandom_range(0, 4)) s = {s, $sformatf(",%0d", $urandom_range(0, 9))};
        add_str({s, "\r\n"});
      end
      9: add_str("+CPIN: READY\r\n");
      10: begin
        case ($urandom_range(0, 2))
          0: s = "+CRING: VOICE"; 1: s = "+CLIP: \"123\",129"; default: s = "+CLCC: 1,0";
        endcase
        add_str({s, "\r\n"});
      end
      11: add_str($sformatf("+CMTI: \"SM\",%0d\r\n", $urandom_range(0, 99)));
      12: add_str("\r\n> ");
      13: add_str("\r\n");
      14, 15: add_str("AT+CSQ\r\n");
      16, 17: begin
        repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) add_str("\r\n");
      end
      default: begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(250, 270)) byte_q.push_back(8'h41);
          add_str("\r\n");
        end else begin
          add_str("+CSQ: 17,99\r\n");
        end
      end
    endcase
  endtask

  initial begin
    logic [7:0] cfg_vals [5];
    cfg_vals = '{8'h00, 8'h5a, 8'hff, 8'h81, 8'h01};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_PENDING, 32'h0000_00ff);
    cfg_write(3'd4, 32'hffff_ffff);   // unused register, must be ignored
    add_str("\r\n");
    add_str("OK\r\n");
    add_str("ERROR\r\n");
    add_str("+CMS ERROR: 65535\r\n");
    add_str("+CME ERROR:+99999\r\n");
    add_str("+CME ERROR: -5\r\n");
    add_str("+CMS ERROR:\r\n");
    add_str("OK\r\n");
    add_str("RING\r\nCONNECT\r\nBUSY\r\nNO ANSWER\r\nNO CARRIER\r\nNO DIALTONE\r\n");
    add_str("+CREG: 0,1,2\r\n");
    add_str("+CREG: 1\r\n");
    add_str("+CPIN: READY\r\n");
    add_str("+CRING: VOICE\r\n+CLIP: \"5\",129\r\n+CLCC: 1\r\n");
    add_str("+CMTI: \"SM\",3\r\n");
    add_str("\r\n> ");
    add_str("OK\r\n> ");
    repeat (300) byte_q.push_back(8'h41);
    add_str("\r\nOK\r\n");
    byte_q.push_back(8'hff);
    byte_q.push_back(8'h00);
    add_str("\r\nERROR\r\n");
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 2) begin
        snd_idle = 15; rcv_idle = 60;
      end else if (ph < 4) begin
        snd_idle = 60; rcv_idle = 15;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      cfg_write(REG_PENDING, {24'h0, cfg_vals[ph]});
      while (byte_q.size() < 130) add_random_line();
      drain();
    end

    $display("fed %0d modem bytes, checked %0d classified replies", n_bytes, n_replies);
    $display("covered all reply kinds, prompts, overflow and five request type settings");
    if (errors == 0) begin
      $display("at_response_classifier_top regression: pass");
    end else begin
      $display("at_response_classifier_top regression: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/arc_pkg.sv
rtl/core/arc_front.sv
rtl/core/arc_queue.sv
rtl/core/arc_back.sv
rtl/core/at_response_classifier_top.sv
rtl/core/arc_checker.sv
tb/at_response_classifier_top_tb.sv
